// ===== rtl/djf_pkg.sv =====
// Package: shared constants, register indexes and the pipeline item type for the joint force block
`default_nettype none
package djf_pkg;

    localparam int FRAC = 16;

    // register indexes on the configuration port
    localparam logic [1:0] REG_REST  = 2'd0;
    localparam logic [1:0] REG_STIFF = 2'd1;
    localparam logic [1:0] REG_MAXF  = 2'd2;

    // stage map
    localparam int ST_DIFF   = 1;
    localparam int ST_SQ     = 2;
    localparam int ST_SUMSQ  = 3;
    localparam int ST_SQRT0  = 4;
    localparam int ROOT_BITS = 34;
    localparam int W_BITS    = 17;
    localparam int ST_LEN    = ST_SQRT0 + ROOT_BITS;
    localparam int ST_DIV0   = ST_LEN + 1;
    localparam int DM_BITS   = 47;
    localparam int ST_KMUL   = ST_DIV0 + DM_BITS;
    localparam int ST_KSUM   = ST_KMUL + 1;
    localparam int ST_FMUL   = ST_KSUM + 1;
    localparam int ST_FSAT   = ST_FMUL + 1;
    localparam int ST_FSQ    = ST_FSAT + 1;
    localparam int ST_SUM    = ST_FSQ + 1;
    localparam int ST_OUT    = ST_SUM + 1;
    localparam int N_ST      = ST_OUT;

    typedef struct packed {
        logic [2:0][31:0] a;
        logic [2:0][31:0] b;
        logic [30:0]      m1;
        logic [30:0]      m2;
        logic [2:0]       neg;
        logic [2:0][32:0] mag;
        logic [31:0]      msum;
        logic [2:0][65:0] sq;
        logic [67:0]      srem;
        logic [33:0]      root;
        logic [47:0]      w1r;
        logic [47:0]      w2r;
        logic [16:0]      w1;
        logic [16:0]      w2;
        logic             diffneg;
        logic [49:0]      drem;
        logic [46:0]      dm;
        logic [17:0]      k1;
        logic [17:0]      k2;
        logic [40:0]      p1h;
        logic [41:0]      p1l;
        logic [40:0]      p2h;
        logic [41:0]      p2l;
        logic [48:0]      c1;
        logic [48:0]      c2;
        logic [2:0][57:0] m1h;
        logic [2:0][56:0] m1l;
        logic [2:0][57:0] m2h;
        logic [2:0][56:0] m2l;
        logic [2:0][31:0] f1m;
        logic [2:0][31:0] f1;
        logic [2:0][31:0] f2;
        logic [2:0][63:0] fsq;
        logic [65:0]      fsum;
        logic             brk;
        logic             zero;
    } t_item;

endpackage
`default_nettype wire

// ===== rtl/djf_in_if.sv =====
// Interface: input channel carrying two particle positions and masses
`default_nettype none
interface djf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] first_x;
    logic [31:0] first_y;
    logic [31:0] first_z;
    logic [31:0] second_x;
    logic [31:0] second_y;
    logic [31:0] second_z;
    logic [30:0] first_mass;
    logic [30:0] second_mass;

    modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                    first_mass, second_mass, input ready);
    modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  first_mass, second_mass, output ready);
endinterface
`default_nettype wire

// ===== rtl/djf_out_if.sv =====
// Interface: output channel carrying the two force vectors and flags
`default_nettype none
interface djf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] force_one_x;
    logic [31:0] force_one_y;
    logic [31:0] force_one_z;
    logic [31:0] force_two_x;
    logic [31:0] force_two_y;
    logic [31:0] force_two_z;
    logic        breaks;
    logic        zero_distance;

    modport source (output valid, force_one_x, force_one_y, force_one_z, force_two_x,
                    force_two_y, force_two_z, breaks, zero_distance, input ready);
    modport sink (input valid, force_one_x, force_one_y, force_one_z, force_two_x,
                  force_two_y, force_two_z, breaks, zero_distance, output ready);
endinterface
`default_nettype wire

// ===== rtl/distance_joint_force.sv =====
// Distance joint spring force: pipelined Q16.16 evaluation of two particle forces
// Usage: positions and masses of two joined particles enter on i_in, one beat a cycle.
// The block forms the separation vector, its length (a bit-per-stage square root),
// the inverse-mass weights and the relative deviation (bit-per-stage dividers),
// scales by stiffness and returns the two force vectors on o_out.
// Each accepted input beat moves through the stage registers in order to its output
// beat; throughput is one beat per cycle while the receiver is ready, set by the
// fully pipelined root, divider and multiplier stages. Valid bits travel with each
// stage. When the receiver stalls with a beat waiting in the output register, the
// whole pipeline holds and i_in.ready drops; nothing is lost or repeated. Coinciding
// particles give zero forces and raise zero_distance. Registers rest_length (0x0),
// stiffness (0x4), max_force (0x8) sit on the APB port; write them only while the
// pipeline is empty. Synchronous active-low reset empties the pipeline and restores
// register defaults: rest length 1.0, stiffness 1.0, max force 0x7FFFFFFF.
`default_nettype none
module distance_joint_force (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    djf_in_if.sink           i_in,
    djf_out_if.source        o_out
);

    logic [30:0] r_rest;
    logic [16:0] r_stiff;
    logic [30:0] r_maxf;
    logic [61:0] r_mf2;

    djf_pkg::t_item r_st [djf_pkg::N_ST+1];
    djf_pkg::t_item n_st [djf_pkg::N_ST+1];
    logic [djf_pkg::N_ST:0] r_vld;
    logic en;

    // configuration
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest  <= 31'd65536;
            r_stiff <= 17'd65536;
            r_maxf  <= 31'h7FFF_FFFF;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                djf_pkg::REG_REST:  r_rest  <= pwdata[30:0];
                djf_pkg::REG_STIFF: r_stiff <= pwdata[16:0];
                djf_pkg::REG_MAXF:  r_maxf  <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_mf2 <= {31'd0, r_maxf} * {31'd0, r_maxf};
    end

    always_comb begin
        unique case (paddr[3:2])
            djf_pkg::REG_REST:  prdata = {1'b0, r_rest};
            djf_pkg::REG_STIFF: prdata = {15'd0, r_stiff};
            djf_pkg::REG_MAXF:  prdata = {1'b0, r_maxf};
            default:            prdata = 32'd0;
        endcase
    end

    // hold every stage while the output beat waits
    assign en = !r_vld[djf_pkg::N_ST] || o_out.ready;
    assign i_in.ready = en;

    always_comb begin
        n_st[0] = r_st[0];
        n_st[0].a[0] = i_in.first_x;
        n_st[0].a[1] = i_in.first_y;
        n_st[0].a[2] = i_in.first_z;
        n_st[0].b[0] = i_in.second_x;
        n_st[0].b[1] = i_in.second_y;
        n_st[0].b[2] = i_in.second_z;
        n_st[0].m1   = i_in.first_mass;
        n_st[0].m2   = i_in.second_mass;
    end

    for (genvar k = 1; k <= djf_pkg::N_ST; k++) begin : g_st
        always_comb begin
            logic [32:0] d;
            logic [67:0] sub;
            logic [65:0] p;
            logic [81:0] fp;
            logic [31:0] cap;
            logic        nn;
            int          bt;
            n_st[k] = r_st[k-1];
            d   = '0;
            sub = '0;
            p   = '0;
            fp  = '0;
            cap = '0;
            nn  = 1'b0;
            bt  = 0;
            if (k == djf_pkg::ST_DIFF) begin
                for (int i = 0; i < 3; i++) begin
                    d = {r_st[k-1].a[i][31], r_st[k-1].a[i]}
                        - {r_st[k-1].b[i][31], r_st[k-1].b[i]};
                    n_st[k].neg[i] = d[32];
                    n_st[k].mag[i] = d[32] ? (33'd0 - d) : d;
                end
                n_st[k].msum = {1'b0, r_st[k-1].m1} + {1'b0, r_st[k-1].m2};
            end
            if (k == djf_pkg::ST_SQ) begin
                for (int i = 0; i < 3; i++)
                    n_st[k].sq[i] = r_st[k-1].mag[i] * r_st[k-1].mag[i];
            end
            if (k == djf_pkg::ST_SUMSQ) begin
                n_st[k].srem = {2'b0, r_st[k-1].sq[0]} + {2'b0, r_st[k-1].sq[1]}
                             + {2'b0, r_st[k-1].sq[2]};
                n_st[k].zero = (r_st[k-1].sq[0] == '0) && (r_st[k-1].sq[1] == '0)
                             && (r_st[k-1].sq[2] == '0);
                n_st[k].root = '0;
                n_st[k].w1r  = {1'b0, r_st[k-1].m2, 16'd0};
                n_st[k].w2r  = {1'b0, r_st[k-1].m1, 16'd0};
                n_st[k].w1   = '0;
                n_st[k].w2   = '0;
            end
            if (k >= djf_pkg::ST_SQRT0 && k < djf_pkg::ST_LEN) begin
                // try one root bit: (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
                bt  = djf_pkg::ROOT_BITS - 1 - (k - djf_pkg::ST_SQRT0);
                sub = ({34'd0, r_st[k-1].root} << (bt + 1)) + (68'd1 << (2 * bt));
                if (r_st[k-1].srem >= sub) begin
                    n_st[k].srem = r_st[k-1].srem - sub;
                    n_st[k].root[bt] = 1'b1;
                end
            end
            if (k >= djf_pkg::ST_SQRT0 && k < djf_pkg::ST_SQRT0 + djf_pkg::W_BITS) begin
                bt = djf_pkg::W_BITS - 1 - (k - djf_pkg::ST_SQRT0);
                if ((r_st[k-1].w1r >> bt) >= {16'd0, r_st[k-1].msum}) begin
                    n_st[k].w1r = r_st[k-1].w1r - ({16'd0, r_st[k-1].msum} << bt);
                    n_st[k].w1[bt] = 1'b1;
                end
                if ((r_st[k-1].w2r >> bt) >= {16'd0, r_st[k-1].msum}) begin
                    n_st[k].w2r = r_st[k-1].w2r - ({16'd0, r_st[k-1].msum} << bt);
                    n_st[k].w2[bt] = 1'b1;
                end
            end
            if (k == djf_pkg::ST_LEN) begin
                if ({3'd0, r_rest} >= r_st[k-1].root) begin
                    n_st[k].drem = {({3'd0, r_rest} - r_st[k-1].root), 16'd0};
                    n_st[k].diffneg = 1'b0;
                end else begin
                    n_st[k].drem = {(r_st[k-1].root - {3'd0, r_rest}), 16'd0};
                    n_st[k].diffneg = 1'b1;
                end
                n_st[k].dm = '0;
                // both masses zero: split evenly
                if (r_st[k-1].msum == '0) begin
                    n_st[k].w1 = 17'd32768;
                    n_st[k].w2 = 17'd32768;
                end
            end
            if (k == djf_pkg::ST_DIV0) begin
                p = {49'd0, r_st[k-1].w1} * {49'd0, r_stiff};
                n_st[k].k1 = p[33:16];
                p = {49'd0, r_st[k-1].w2} * {49'd0, r_stiff};
                n_st[k].k2 = p[33:16];
            end
            if (k >= djf_pkg::ST_DIV0 && k < djf_pkg::ST_KMUL) begin
                bt = djf_pkg::DM_BITS - 1 - (k - djf_pkg::ST_DIV0);
                if ((r_st[k-1].drem >> bt) >= {16'd0, r_st[k-1].root}) begin
                    n_st[k].drem = r_st[k-1].drem - ({16'd0, r_st[k-1].root} << bt);
                    n_st[k].dm[bt] = 1'b1;
                end
            end
            if (k == djf_pkg::ST_KMUL) begin
                n_st[k].p1h = r_st[k-1].k1 * r_st[k-1].dm[46:24];
                n_st[k].p1l = r_st[k-1].k1 * r_st[k-1].dm[23:0];
                n_st[k].p2h = r_st[k-1].k2 * r_st[k-1].dm[46:24];
                n_st[k].p2l = r_st[k-1].k2 * r_st[k-1].dm[23:0];
            end
            if (k == djf_pkg::ST_KSUM) begin
                p = ({25'd0, r_st[k-1].p1h} << 24) + {24'd0, r_st[k-1].p1l};
                n_st[k].c1 = (p[65:16] > 50'h1_0000_0000_0000) ? 49'h1_0000_0000_0000
                                                               : p[64:16];
                p = ({25'd0, r_st[k-1].p2h} << 24) + {24'd0, r_st[k-1].p2l};
                n_st[k].c2 = (p[65:16] > 50'h1_0000_0000_0000) ? 49'h1_0000_0000_0000
                                                               : p[64:16];
            end
            if (k == djf_pkg::ST_FMUL) begin
                for (int i = 0; i < 3; i++) begin
                    n_st[k].m1h[i] = r_st[k-1].mag[i] * r_st[k-1].c1[48:24];
                    n_st[k].m1l[i] = r_st[k-1].mag[i] * r_st[k-1].c1[23:0];
                    n_st[k].m2h[i] = r_st[k-1].mag[i] * r_st[k-1].c2[48:24];
                    n_st[k].m2l[i] = r_st[k-1].mag[i] * r_st[k-1].c2[23:0];
                end
            end
            if (k == djf_pkg::ST_FSAT) begin
                for (int i = 0; i < 3; i++) begin
                    nn  = r_st[k-1].neg[i] ^ r_st[k-1].diffneg;
                    cap = nn ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    fp  = ({r_st[k-1].m1h[i]} << 24) + {25'd0, r_st[k-1].m1l[i]};
                    n_st[k].f1m[i] = (fp[81:16] > {34'd0, cap}) ? cap : fp[47:16];
                    n_st[k].f1[i]  = nn ? (32'd0 - n_st[k].f1m[i]) : n_st[k].f1m[i];
                    cap = nn ? 32'h7FFF_FFFF : 32'h8000_0000;
                    fp  = ({r_st[k-1].m2h[i]} << 24) + {25'd0, r_st[k-1].m2l[i]};
                    n_st[k].f2[i]  = (fp[81:16] > {34'd0, cap}) ? cap : fp[47:16];
                    n_st[k].f2[i]  = nn ? n_st[k].f2[i] : (32'd0 - n_st[k].f2[i]);
                end
            end
            if (k == djf_pkg::ST_FSQ) begin
                for (int i = 0; i < 3; i++)
                    n_st[k].fsq[i] = r_st[k-1].f1m[i] * r_st[k-1].f1m[i];
            end
            if (k == djf_pkg::ST_SUM) begin
                n_st[k].fsum = {2'b0, r_st[k-1].fsq[0]} + {2'b0, r_st[k-1].fsq[1]}
                             + {2'b0, r_st[k-1].fsq[2]};
            end
            if (k == djf_pkg::ST_OUT) begin
                n_st[k].brk = !r_st[k-1].zero && (r_st[k-1].fsum >= {4'd0, r_mf2});
                if (r_st[k-1].zero) begin
                    n_st[k].f1 = '0;
                    n_st[k].f2 = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[djf_pkg::N_ST-1:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k <= djf_pkg::N_ST; k++)
                r_st[k] <= n_st[k];
        end
    end

    assign o_out.valid         = r_vld[djf_pkg::N_ST];
    assign o_out.force_one_x   = r_st[djf_pkg::N_ST].f1[0];
    assign o_out.force_one_y   = r_st[djf_pkg::N_ST].f1[1];
    assign o_out.force_one_z   = r_st[djf_pkg::N_ST].f1[2];
    assign o_out.force_two_x   = r_st[djf_pkg::N_ST].f2[0];
    assign o_out.force_two_y   = r_st[djf_pkg::N_ST].f2[1];
    assign o_out.force_two_z   = r_st[djf_pkg::N_ST].f2[2];
    assign o_out.breaks        = r_st[djf_pkg::N_ST].brk;
    assign o_out.zero_distance = r_st[djf_pkg::N_ST].zero;

endmodule
`default_nettype wire

// ===== tb/distance_joint_force_tb.sv =====
// Testbench for the distance joint force block: streamed joints checked against a fixed-point predictor
`timescale 1ns / 1ps
`default_nettype none
module distance_joint_force_tb;

    typedef struct {
        logic [31:0] a [3];
        logic [31:0] b [3];
        logic [30:0] m1;
        logic [30:0] m2;
    } t_joint;

    typedef struct {
        logic [31:0] f1 [3];
        logic [31:0] f2 [3];
        logic        brk;
        logic        zero;
    } t_force;

    localparam int LAT      = 93;
    localparam int WD_LIMIT = 20000;
    localparam int N_RAND   = 600;

    class force_board;
        logic [30:0] rest_len;
        logic [16:0] stiff;
        logic [30:0] max_f;
        t_force      pending[$];
        int          errors;
        int          checked;
        int          n_break;
        int          n_zero;

        function new();
            rest_len = 31'h10000;
            stiff    = 17'h10000;
            max_f    = 31'h7fffffff;
            errors   = 0;
            checked  = 0;
            n_break  = 0;
            n_zero   = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] v);
            case (idx)
                djf_pkg::REG_REST:  rest_len = v[30:0];
                djf_pkg::REG_STIFF: stiff    = v[16:0];
                djf_pkg::REG_MAXF:  max_f    = v[30:0];
                default: ;
            endcase
        endfunction

        // (a*b) >> FRAC, saturated to cap
        function automatic logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b,
                                                logic [63:0] cap);
            logic [127:0] p;
            p = (128'(a) * 128'(b)) >> djf_pkg::FRAC;
            return (p > 128'(cap)) ? cap : p[63:0];
        endfunction

        function automatic t_force joint_force(t_joint j);
            t_force       r;
            logic [63:0]  mag [3];
            logic         dneg [3];
            logic [127:0] ssq;
            logic [63:0]  len, t, w1, w2, k1, k2, dm, c1, c2, cap, m;
            logic [127:0] sq;
            logic         dfn, n1;
            longint       d;
            ssq = 0;
            for (int i = 0; i < 3; i++) begin
                d = longint'($signed(j.a[i])) - longint'($signed(j.b[i]));
                dneg[i] = d < 0;
                mag[i] = dneg[i] ? 64'(-d) : 64'(d);
                ssq += 128'(mag[i]) * 128'(mag[i]);
            end
            if (ssq == 0) begin
                for (int i = 0; i < 3; i++) begin
                    r.f1[i] = 0;
                    r.f2[i] = 0;
                end
                r.brk  = 0;
                r.zero = 1;
                return r;
            end
            len = 0;
            for (int b = 33; b >= 0; b--) begin
                t = len | (64'd1 << b);
                if (128'(t) * 128'(t) <= ssq) len = t;
            end
            m = 64'(j.m1) + 64'(j.m2);
            if (m == 0) begin
                w1 = 64'd1 << (djf_pkg::FRAC - 1);
                w2 = w1;
            end else begin
                w1 = (64'(j.m2) << djf_pkg::FRAC) / m;
                w2 = (64'(j.m1) << djf_pkg::FRAC) / m;
            end
            k1 = (w1 * 64'(stiff)) >> djf_pkg::FRAC;
            k2 = (w2 * 64'(stiff)) >> djf_pkg::FRAC;
            dfn = len > 64'(rest_len);
            dm = dfn ? ((len - 64'(rest_len)) << djf_pkg::FRAC) / len
                     : ((64'(rest_len) - len) << djf_pkg::FRAC) / len;
            cap = 64'd1 << (32 + djf_pkg::FRAC);
            c1 = mul_sat(k1, dm, cap);
            c2 = mul_sat(k2, dm, cap);
            sq = 0;
            for (int i = 0; i < 3; i++) begin
                n1 = dneg[i] != dfn;
                t = mul_sat(mag[i], c1, n1 ? 64'h80000000 : 64'h7fffffff);
                r.f1[i] = n1 ? 32'(-t) : t[31:0];
                sq += 128'(t) * 128'(t);
                t = mul_sat(mag[i], c2, !n1 ? 64'h80000000 : 64'h7fffffff);
                r.f2[i] = !n1 ? 32'(-t) : t[31:0];
            end
            r.brk  = sq >= 128'(max_f) * 128'(max_f);
            r.zero = 0;
            return r;
        endfunction

        function void note_joint(t_joint j);
            pending.push_back(joint_force(j));
        endfunction

        function void check_force(t_force got);
            t_force e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat", $time);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.brk) n_break++;
            if (got.zero) n_zero++;
            for (int i = 0; i < 3; i++) begin
                if (got.f1[i] !== e.f1[i]) begin
                    $display("%0t: force_one[%0d] exp %h got %h", $time, i, e.f1[i], got.f1[i]);
                    errors++;
                end
                if (got.f2[i] !== e.f2[i]) begin
                    $display("%0t: force_two[%0d] exp %h got %h", $time, i, e.f2[i], got.f2[i]);
                    errors++;
                end
            end
            if (got.brk !== e.brk) begin
                $display("%0t: breaks exp %b got %b", $time, e.brk, got.brk);
                errors++;
            end
            if (got.zero !== e.zero) begin
                $display("%0t: zero_distance exp %b got %b", $time, e.zero, got.zero);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    djf_in_if  in_ch ();
    djf_out_if out_ch ();

    distance_joint_force dut (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    force_board board = new();
    int  idle_cycles = 0;
    bit  hold_off = 0;
    bit  stall_mode = 0;

    always #6 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 0;
        in_ch.first_x = 0; in_ch.first_y = 0; in_ch.first_z = 0;
        in_ch.second_x = 0; in_ch.second_y = 0; in_ch.second_z = 0;
        in_ch.first_mass = 0; in_ch.second_mass = 0;
        out_ch.ready = 0;
    end

    // receiver: stall pattern, or a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_off)
            out_ch.ready <= 1'b0;
        else if (stall_mode)
            out_ch.ready <= ($urandom_range(0, 3) != 0);
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        t_force got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.f1[0] = out_ch.force_one_x; got.f1[1] = out_ch.force_one_y;
            got.f1[2] = out_ch.force_one_z;
            got.f2[0] = out_ch.force_two_x; got.f2[1] = out_ch.force_two_y;
            got.f2[2] = out_ch.force_two_z;
            got.brk  = out_ch.breaks;
            got.zero = out_ch.zero_distance;
            board.check_force(got);
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WD_LIMIT) begin
                $display("[distance_joint_force] ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        board.set_reg(idx, v);
    endtask

    // send one beat; sender gap already handled by caller
    task automatic send_joint(t_joint j);
        in_ch.valid <= 1;
        in_ch.first_x <= j.a[0]; in_ch.first_y <= j.a[1]; in_ch.first_z <= j.a[2];
        in_ch.second_x <= j.b[0]; in_ch.second_y <= j.b[1]; in_ch.second_z <= j.b[2];
        in_ch.first_mass <= j.m1; in_ch.second_mass <= j.m2;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_joint(j);
    endtask

    int burst_left = 0;

    task automatic offer(t_joint j);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 2) == 0) begin
                in_ch.valid <= 0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        send_joint(j);
    endtask

    // drop valid at the edge that took the last beat
    task automatic drain();
        in_ch.valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LAT + 5) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 32'h000fffff)) - 32'sh80000);
        endcase
    endfunction

    function automatic logic [30:0] rand_mass();
        case ($urandom_range(0, 7))
            0: return 31'h7fffffff;
            1: return 31'd1;
            2: return 31'($urandom());
            default: return 31'($urandom_range(1, 32'h00100000));
        endcase
    endfunction

    function automatic t_joint rand_joint();
        t_joint j;
        for (int i = 0; i < 3; i++) begin
            j.a[i] = rand_pos();
            j.b[i] = ($urandom_range(0, 15) == 0) ? j.a[i] : rand_pos();
        end
        j.m1 = rand_mass();
        j.m2 = rand_mass();
        return j;
    endfunction

    function automatic t_joint mk(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                                  logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                                  logic [30:0] m1, logic [30:0] m2);
        t_joint j;
        j.a[0] = ax; j.a[1] = ay; j.a[2] = az;
        j.b[0] = bx; j.b[1] = by; j.b[2] = bz;
        j.m1 = m1; j.m2 = m2;
        return j;
    endfunction

    task automatic run_random(int n);
        for (int i = 0; i < n; i++) offer(rand_joint());
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: coincidence, extremes, mass corner cases
        send_joint(mk(0, 0, 0, 0, 0, 0, 31'h10000, 31'h10000));
        send_joint(mk(32'h12345678, 5, 32'h80000000, 32'h12345678, 5, 32'h80000000, 1, 1));
        send_joint(mk(32'h20000, 0, 0, 0, 0, 0, 31'h10000, 31'h10000));
        send_joint(mk(32'h8000, 0, 0, 0, 0, 0, 31'h10000, 31'h30000));
        send_joint(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                      32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff, 31'h7fffffff));
        send_joint(mk(32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000, 0, 1, 31'h7fffffff));
        send_joint(mk(0, 0, 1, 0, 0, 0, 0, 0));
        send_joint(mk(0, 1, 0, 0, 0, 0, 0, 31'h10000));
        send_joint(mk(32'hffffffff, 0, 0, 0, 0, 0, 31'h10000, 0));
        send_joint(mk(0, 32'h10000, 0, 0, 0, 0, 31'h55555, 31'h7fffffff));
        send_joint(mk(32'hfff00000, 32'h00100000, 32'hffff0000, 3, 4, 5, 31'h1000, 31'h2000));
        drain();

        write_reg(djf_pkg::REG_REST, 32'hffffffff);
        write_reg(djf_pkg::REG_STIFF, 32'hfffe0000 | 17'h1ffff);
        write_reg(djf_pkg::REG_MAXF, 0);
        send_joint(mk(0, 0, 1, 0, 0, 0, 1, 1));
        send_joint(mk(32'h7fffffff, 0, 0, 32'h80000000, 0, 0, 31'h10000, 31'h10000));
        run_random(150);
        drain();

        write_reg(djf_pkg::REG_REST, 0);
        write_reg(djf_pkg::REG_STIFF, 0);
        write_reg(djf_pkg::REG_MAXF, 32'h7fffffff);
        run_random(100);
        drain();

        write_reg(djf_pkg::REG_REST, 32'h00030000);
        write_reg(djf_pkg::REG_STIFF, 32'h00008000);
        write_reg(djf_pkg::REG_MAXF, 32'h00040000);
        // receiver holds off for a long stretch while the sender keeps offering
        stall_mode = 1;
        fork
            run_random(200);
            begin
                @(posedge i_clk);
                hold_off = 1;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
        join
        drain();

        write_reg(djf_pkg::REG_REST, 32'h00010000);
        write_reg(djf_pkg::REG_STIFF, 32'h00010000);
        write_reg(djf_pkg::REG_MAXF, 32'h00001000);
        stall_mode = 0;
        run_random(150);
        drain();

        $display("Checked %0d force results over five register settings.", board.checked);
        $display("Break flags seen: %0d, coincident joints seen: %0d.",
                 board.n_break, board.n_zero);
        if (board.errors == 0)
            $display("[distance_joint_force] OK");
        else
            $display("[distance_joint_force] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/djf_pkg.sv
rtl/djf_in_if.sv
rtl/djf_out_if.sv
rtl/distance_joint_force.sv
tb/distance_joint_force_tb.sv
